// ===== hw/rtl/two_wire_serial_frame_master_assert.svh =====
// Assertion macros for the serial frame master core module.
`ifndef TWO_WIRE_SERIAL_FRAME_MASTER_ASSERT_SVH
`define TWO_WIRE_SERIAL_FRAME_MASTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWSFM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serial frame master: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TWSFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serial frame master: next-cycle check failed");

`endif

// ===== hw/rtl/twsfm_pkg.sv =====
`default_nettype none

package twsfm_pkg;

   localparam int DATA_BITS    = 8;
   localparam int ADDRESS_BITS = 16;
   localparam int COMMAND_BITS = 8;

   localparam int SHIFT_BITS  = DATA_BITS + ADDRESS_BITS + COMMAND_BITS;
   localparam int SHIFT_IDX_W = $clog2(SHIFT_BITS);
   localparam int DATA_IDX_W  = $clog2(DATA_BITS);

   // Phases of a whole frame: turnaround, sent bits and, for a read, release and read bits.
   localparam int WRITE_PHASES = 2 + 2 * SHIFT_BITS;
   localparam int READ_PHASES  = 2 + 2 * (ADDRESS_BITS + COMMAND_BITS) + 2 + 2 * DATA_BITS;
   localparam int MAX_PHASES   = (WRITE_PHASES > READ_PHASES) ? WRITE_PHASES : READ_PHASES;
   localparam int PHASE_W      = $clog2(MAX_PHASES + 1);

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [COMMAND_BITS-1:0] command;
      logic [ADDRESS_BITS-1:0] target_address;
      logic [DATA_BITS-1:0]    write_byte;
      logic                    line_in;
   } item_type;

   typedef struct packed {
      logic                 clock_level;
      logic                 line_out;
      logic                 line_drive;
      logic                 busy_res;
      logic [DATA_BITS-1:0] read_byte;
      logic                 read_done;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/twsfm_frame_core.sv =====
`default_nettype none

module twsfm_frame_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire twsfm_pkg::item_type   item,
   output      twsfm_pkg::result_type result
);

   logic [twsfm_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [twsfm_pkg::SHIFT_BITS-1:0] shift_ff, shift_in;
   logic                             is_read_ff, is_read_in;
   logic                             active_ff, active_in;
   logic [twsfm_pkg::DATA_BITS-1:0]  rd_shift_ff, rd_shift_in;
   logic                             clk_lvl_ff, clk_lvl_in;
   logic                             dat_lvl_ff, dat_lvl_in;
   logic                             drive_ff, drive_in;
   logic                             done;

   logic                             is_tick, is_start;
   logic [twsfm_pkg::PHASE_W-1:0]    send_phases, total_phases;
   logic [twsfm_pkg::PHASE_W-1:0]    m_phase, r_phase, r2_phase, k_bit, phase_next;
   logic [twsfm_pkg::SHIFT_IDX_W-1:0] bit_idx;
   logic [twsfm_pkg::DATA_IDX_W-1:0]  rd_idx;

   assign is_tick  = step && (item.req_type == twsfm_pkg::REQ_TICK) && active_ff;
   assign is_start = step && !active_ff &&
                     ((item.req_type == twsfm_pkg::REQ_WRITE) ||
                      (item.req_type == twsfm_pkg::REQ_READ));

   assign send_phases  = is_read_ff ?
      twsfm_pkg::PHASE_W'(2 * (twsfm_pkg::ADDRESS_BITS + twsfm_pkg::COMMAND_BITS)) :
      twsfm_pkg::PHASE_W'(2 * twsfm_pkg::SHIFT_BITS);
   assign total_phases = is_read_ff ? twsfm_pkg::PHASE_W'(twsfm_pkg::READ_PHASES) :
                                      twsfm_pkg::PHASE_W'(twsfm_pkg::WRITE_PHASES);

   // Position within the sent bits, then within the release and read section.
   assign m_phase    = phase_ff - twsfm_pkg::PHASE_W'(2);
   assign r_phase    = m_phase - send_phases;
   assign r2_phase   = r_phase - twsfm_pkg::PHASE_W'(2);
   assign k_bit      = r2_phase >> 1;
   assign bit_idx    = m_phase[twsfm_pkg::SHIFT_IDX_W:1];
   assign rd_idx     = k_bit[twsfm_pkg::DATA_IDX_W-1:0];
   assign phase_next = phase_ff + twsfm_pkg::PHASE_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      shift_in    = shift_ff;
      is_read_in  = is_read_ff;
      active_in   = active_ff;
      rd_shift_in = rd_shift_ff;
      clk_lvl_in  = clk_lvl_ff;
      dat_lvl_in  = dat_lvl_ff;
      drive_in    = drive_ff;
      done        = 1'b0;
      priority if (is_tick) begin
         if (phase_ff < twsfm_pkg::PHASE_W'(2)) begin
            // Turnaround: the data line keeps its last level.
            drive_in   = 1'b1;
            clk_lvl_in = (phase_ff == '0);
         end else if (m_phase < send_phases) begin
            dat_lvl_in = shift_ff[bit_idx];
            drive_in   = 1'b1;
            clk_lvl_in = !m_phase[0];
         end else begin
            drive_in = 1'b0;
            if (r_phase < twsfm_pkg::PHASE_W'(2)) begin
               clk_lvl_in = r_phase[0];
            end else begin
               clk_lvl_in = r2_phase[0];
               if (r2_phase[0] && (k_bit < twsfm_pkg::PHASE_W'(twsfm_pkg::DATA_BITS))) begin
                  rd_shift_in[rd_idx] = rd_shift_ff[rd_idx] | item.line_in;
               end
            end
         end
         phase_in = phase_next;
         if (phase_next >= total_phases) begin
            active_in = 1'b0;
            done      = is_read_ff;
         end
      end else if (is_start) begin
         is_read_in  = (item.req_type == twsfm_pkg::REQ_READ);
         shift_in    = is_read_in ?
            {{twsfm_pkg::DATA_BITS{1'b0}}, item.command, item.target_address} :
            {item.command, item.target_address, item.write_byte};
         rd_shift_in = '0;
         phase_in    = '0;
         active_in   = 1'b1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         shift_ff    <= '0;
         is_read_ff  <= 1'b0;
         active_ff   <= 1'b0;
         rd_shift_ff <= '0;
         clk_lvl_ff  <= 1'b0;
         dat_lvl_ff  <= 1'b0;
         drive_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         shift_ff    <= shift_in;
         is_read_ff  <= is_read_in;
         active_ff   <= active_in;
         rd_shift_ff <= rd_shift_in;
         clk_lvl_ff  <= clk_lvl_in;
         dat_lvl_ff  <= dat_lvl_in;
         drive_ff    <= drive_in;
      end
   end

   assign result.clock_level = clk_lvl_in;
   assign result.line_out    = dat_lvl_in;
   assign result.line_drive  = drive_in;
   assign result.busy_res    = active_in;
   assign result.read_byte   = rd_shift_in;
   assign result.read_done   = done;

`include "two_wire_serial_frame_master_assert.svh"

   `TWSFM_ASSERT_SAME(a_phase_in_range, clock, reset, active_ff, phase_ff < total_phases)
   `TWSFM_ASSERT_SAME(a_done_only_read, clock, reset, done, is_read_ff && is_tick)
   `TWSFM_ASSERT_NEXT(a_start_opens_frame, clock, reset, is_start,
                      active_ff && (phase_ff == '0) && (rd_shift_ff == '0))
   `TWSFM_ASSERT_NEXT(a_idle_holds_lines, clock, reset, !active_ff && !is_start,
                      $stable(clk_lvl_ff) && $stable(dat_lvl_ff) && $stable(drive_ff))

endmodule

`default_nettype wire

// ===== hw/rtl/two_wire_serial_frame_master.sv =====
`default_nettype none

// Channel   Direction  Contents
// req_      in         tuser: request kind; tdata: command, address, write byte, line level
// rsp_      out        tdata: clock, data level, drive, busy, read byte, read done
//
// One request item gives one response item. Items pass through an input register and a
// response register with the frame state updated in between, so one item a cycle flows
// when rsp_tready stays high.
// A stalled response holds the input register, and a new request is still taken while the
// input register empties into the free response slot.
// Reset is synchronous and leaves the frame idle with all lines low and released.

module two_wire_serial_frame_master (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] command, [23:8] target_address, [31:24] write_byte, [32] line_in, [39:33] zero
   input  wire logic [39:0] req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] clock_level, [1] line_out, [2] line_drive, [3] busy_res, [11:4] read_byte,
   // [12] read_done, [15:13] zero
   output      logic [15:0] rsp_tdata
);

   logic                  in_valid_ff, in_valid_in;
   twsfm_pkg::item_type   in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   twsfm_pkg::result_type out_res_ff, out_res_in;
   twsfm_pkg::result_type core_res;
   logic                  req_take, advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.req_type       = req_tuser;
      in_item_in.command        = req_tdata[7:0];
      in_item_in.target_address = req_tdata[23:8];
      in_item_in.write_byte     = req_tdata[31:24];
      in_item_in.line_in        = req_tdata[32];
      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_res_in = core_res;
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   twsfm_frame_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_res_ff.read_done,
                        out_res_ff.read_byte,
                        out_res_ff.busy_res,
                        out_res_ff.line_drive,
                        out_res_ff.line_out,
                        out_res_ff.clock_level};

endmodule

`default_nettype wire

// ===== tb/two_wire_serial_frame_master_test.sv =====
module two_wire_serial_frame_master_test;

   // Request code three has no meaning to the block and must leave it untouched.
   localparam logic [1:0] REQ_NOP = 2'd3;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_START  = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_FROM  = 900;
   localparam int QUIET_UNTIL = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = twsfm_pkg::REQ_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   two_wire_serial_frame_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   twsfm_pkg::item_type   queued_requests[$];
   twsfm_pkg::result_type predicted_responses[$];
   twsfm_pkg::item_type   offered_item;

   // Frame state as the block should hold it.
   logic [6:0]  phase_num = '0;
   logic [31:0] frame_bits = '0;
   logic        frame_is_read = 1'b0;
   logic        frame_busy = 1'b0;
   logic [7:0]  gathered_byte = '0;
   logic        scl_level = 1'b0;
   logic        sda_level = 1'b0;
   logic        sda_driven = 1'b0;

   int cycle_count = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   int mismatches = 0;
   int responses_checked = 0;
   int writes_started = 0;
   int reads_started = 0;
   int reads_finished = 0;
   int items_sent = 0;

   wire quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_UNTIL;

   function automatic twsfm_pkg::result_type advance_frame(twsfm_pkg::item_type it);
      twsfm_pkg::result_type r;
      int send_bits;
      int total;
      int m;
      int k;
      logic done;
      done = 1'b0;
      if (it.req_type == twsfm_pkg::REQ_TICK && frame_busy) begin
         send_bits = frame_is_read ?
            twsfm_pkg::ADDRESS_BITS + twsfm_pkg::COMMAND_BITS :
            twsfm_pkg::DATA_BITS + twsfm_pkg::ADDRESS_BITS + twsfm_pkg::COMMAND_BITS;
         total = 2 + 2 * send_bits + (frame_is_read ? 2 + 2 * twsfm_pkg::DATA_BITS : 0);
         if (phase_num < 2) begin
            // Turnaround: the data level is left as it was.
            sda_driven = 1'b1;
            scl_level  = (phase_num == 0);
         end else begin
            m = phase_num - 2;
            if (m < 2 * send_bits) begin
               sda_level  = frame_bits[m >> 1];
               sda_driven = 1'b1;
               scl_level  = ~m[0];
            end else begin
               m = m - 2 * send_bits;
               sda_driven = 1'b0;
               if (m < 2) begin
                  scl_level = m[0];
               end else begin
                  m = m - 2;
                  k = m >> 1;
                  scl_level = m[0];
                  if (scl_level && k < twsfm_pkg::DATA_BITS)
                     gathered_byte[k] = gathered_byte[k] | it.line_in;
               end
            end
         end
         phase_num = phase_num + 7'd1;
         if (phase_num >= total) begin
            frame_busy = 1'b0;
            done = frame_is_read;
         end
      end else if ((it.req_type == twsfm_pkg::REQ_WRITE || it.req_type == twsfm_pkg::REQ_READ)
                   && !frame_busy) begin
         frame_is_read = (it.req_type == twsfm_pkg::REQ_READ);
         frame_bits = frame_is_read ? {8'd0, it.command, it.target_address}
                                    : {it.command, it.target_address, it.write_byte};
         gathered_byte = '0;
         phase_num = '0;
         frame_busy = 1'b1;
      end
      r.clock_level = scl_level;
      r.line_out    = sda_level;
      r.line_drive  = sda_driven;
      r.busy_res    = frame_busy;
      r.read_byte   = gathered_byte;
      r.read_done   = done;
      return r;
   endfunction

   task automatic add_request(logic [1:0] kind, logic [7:0] cmd, logic [15:0] addr,
                              logic [7:0] wbyte, logic level);
      twsfm_pkg::item_type it;
      it.req_type       = kind;
      it.command        = cmd;
      it.target_address = addr;
      it.write_byte     = wbyte;
      it.line_in        = level;
      queued_requests.push_back(it);
   endtask

   // Ticks and stray requests carry random contents too; of a tick the block reads only the line level.
   task automatic add_random(logic [1:0] kind);
      add_request(kind, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sender: offers items from the queue, idling now and then.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (!frame_busy && offered_item.req_type == twsfm_pkg::REQ_WRITE) writes_started++;
            if (!frame_busy && offered_item.req_type == twsfm_pkg::REQ_READ) reads_started++;
            predicted_responses.push_back(advance_frame(offered_item));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (queued_requests.size() > 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
               offered_item = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered_item.req_type;
               req_tdata  <= {7'd0, offered_item.line_in, offered_item.write_byte,
                              offered_item.target_address, offered_item.command};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each item against the oldest prediction and applies back-pressure.
   always @(posedge clock) begin
      twsfm_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = predicted_responses.pop_front();
               check_field("clock_level", want.clock_level, rsp_tdata[0]);
               check_field("line_out", want.line_out, rsp_tdata[1]);
               check_field("line_drive", want.line_drive, rsp_tdata[2]);
               check_field("busy_res", want.busy_res, rsp_tdata[3]);
               check_field("read_byte", want.read_byte, rsp_tdata[11:4]);
               check_field("read_done", want.read_done, rsp_tdata[12]);
               check_field("padding", 0, rsp_tdata[15:13]);
               if (want.read_done) reads_finished++;
               responses_checked++;
            end
         end
         if (cycle_count == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || $urandom_range(0, 99) >= 26;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("FAIL");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int n;
      logic [1:0] kind;

      // Idle tick and the unused request code before anything has started.
      add_request(twsfm_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00, 1'b0);
      add_request(REQ_NOP, 8'hff, 16'hffff, 8'hff, 1'b1);
      // Write frame with every field at its maximum; starts and a no-op during it are ignored.
      add_request(twsfm_pkg::REQ_WRITE, 8'hff, 16'hffff, 8'hff, 1'b1);
      add_request(twsfm_pkg::REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0);
      repeat (30) add_request(twsfm_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00, 1'b1);
      add_request(REQ_NOP, 8'h00, 16'h0000, 8'h00, 1'b0);
      add_request(twsfm_pkg::REQ_WRITE, 8'h00, 16'h0000, 8'h00, 1'b0);
      repeat (twsfm_pkg::WRITE_PHASES - 30 + 2)
         add_request(twsfm_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00, 1'b1);
      // Read frame with zero address and command, the line held high throughout.
      add_request(twsfm_pkg::REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0);
      add_request(twsfm_pkg::REQ_WRITE, 8'hff, 16'hffff, 8'hff, 1'b1);
      repeat (twsfm_pkg::READ_PHASES + 1)
         add_request(twsfm_pkg::REQ_TICK, 8'hff, 16'hffff, 8'hff, 1'b1);
      // Read frame with alternating contents, the line low throughout.
      add_request(twsfm_pkg::REQ_READ, 8'ha5, 16'h5ac3, 8'h3c, 1'b1);
      repeat (twsfm_pkg::READ_PHASES)
         add_request(twsfm_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00, 1'b0);
      // Write frame of all zeros straight after.
      add_request(twsfm_pkg::REQ_WRITE, 8'h00, 16'h0000, 8'h00, 1'b0);
      repeat (twsfm_pkg::WRITE_PHASES)
         add_request(twsfm_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00, 1'b0);

      // Mostly complete frames with random contents, the rest loose requests.
      while (queued_requests.size() < 1000) begin
         if ($urandom_range(0, 99) < 80) begin
            kind = $urandom_range(0, 1) ? twsfm_pkg::REQ_READ : twsfm_pkg::REQ_WRITE;
            add_random(kind);
            n = (kind == twsfm_pkg::REQ_READ ? twsfm_pkg::READ_PHASES : twsfm_pkg::WRITE_PHASES)
                + $urandom_range(0, 3);
            repeat (n) begin
               if ($urandom_range(0, 99) < 3) add_random(2'($urandom_range(1, 3)));
               add_random(twsfm_pkg::REQ_TICK);
            end
         end else begin
            repeat ($urandom_range(1, 8)) add_random(2'($urandom_range(0, 3)));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || req_tvalid || predicted_responses.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d items: %0d write and %0d read frames started, %0d reads completed.",
               items_sent, writes_started, reads_started, reads_finished);
      $display("Checked %0d responses, with a %0d-cycle receiver hold-off, %0d mismatches.",
               responses_checked, HOLD_CYCLES, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/twsfm_pkg.sv
hw/rtl/twsfm_frame_core.sv
hw/rtl/two_wire_serial_frame_master.sv
tb/two_wire_serial_frame_master_test.sv
